@@ rtl/ckmer_pkg.sv @@
// Package for the canonical k-mer indexer: base decoding, register indexes,
// field widths and the status bundle passed from the window unit to the top.
// No dependencies.
package ckmer_pkg;

  // Field widths fixed by the result format.
  localparam int unsigned POS_W   = 28;
  localparam int unsigned BLK_W   = 25;
  localparam int unsigned CANON_W = 32;
  localparam int unsigned BSIZE_W = 16;
  localparam int unsigned STRIDE_W = 8;
  localparam int unsigned CFG_W   = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [BLK_W-1:0] BLK_MAX = {BLK_W{1'b1}};

  localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST    = 16'd500;
  localparam logic [STRIDE_W-1:0] SAMPLE_STRIDE_RST = 8'd10;

  // Configuration register indexes.
  localparam logic CFG_BLOCK_SIZE    = 1'b0;
  localparam logic CFG_SAMPLE_STRIDE = 1'b1;

  // ASCII nucleotide bytes.
  localparam logic [7:0] CHAR_A_UP = 8'd65;
  localparam logic [7:0] CHAR_A_LO = 8'd97;
  localparam logic [7:0] CHAR_T_UP = 8'd84;
  localparam logic [7:0] CHAR_T_LO = 8'd116;
  localparam logic [7:0] CHAR_C_UP = 8'd67;
  localparam logic [7:0] CHAR_C_LO = 8'd99;
  localparam logic [7:0] CHAR_G_UP = 8'd71;
  localparam logic [7:0] CHAR_G_LO = 8'd103;

  // Two-bit base codes; the complement of a code is the code XOR 1.
  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_T = 2'd1;
  localparam logic [1:0] CODE_C = 2'd2;
  localparam logic [1:0] CODE_G = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [1:0] bits;
  } base_code_t;

  typedef struct packed {
    logic full;       // K bases of the current sequence have arrived
    logic clean;      // every base in the window is ACGT
  } win_status_t;

  // Invalid bytes decode to code 0 with ok cleared.
  function automatic base_code_t decode_base(input logic [7:0] c);
    base_code_t r;
    r.ok   = 1'b1;
    r.bits = CODE_A;
    case (c) inside
      CHAR_A_UP, CHAR_A_LO: r.bits = CODE_A;
      CHAR_T_UP, CHAR_T_LO: r.bits = CODE_T;
      CHAR_C_UP, CHAR_C_LO: r.bits = CODE_C;
      CHAR_G_UP, CHAR_G_LO: r.bits = CODE_G;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ckmer_window.sv @@
// Rolling forward and reverse-complement k-mer windows with base counters.
// Produces the post-step window status and canonical index combinationally.
// Depends on ckmer_pkg.
module ckmer_window #(
  parameter int unsigned KMER_LEN = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           seq_start,
  input  ckmer_pkg::base_code_t          code,
  output ckmer_pkg::win_status_t         status,
  output logic [ckmer_pkg::CANON_W-1:0]  canon
);
  import ckmer_pkg::*;

  localparam int unsigned WIN_W = 2 * KMER_LEN;
  localparam int unsigned CNT_W = $clog2(KMER_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(KMER_LEN);

  logic [WIN_W-1:0] fwd_r, fwd_nxt, fwd_base;
  logic [WIN_W-1:0] rev_r, rev_nxt, rev_base;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_base;
  logic [CNT_W-1:0] run_r, run_nxt, run_base;
  logic [WIN_W-1:0] min_win;

  always_comb begin
    fwd_base = seq_start ? '0 : fwd_r;
    rev_base = seq_start ? '0 : rev_r;
    cnt_base = seq_start ? '0 : cnt_r;
    run_base = seq_start ? '0 : run_r;

    // Newest base enters the low end of the forward window and, complemented,
    // the high end of the reverse window.
    fwd_nxt = (fwd_base << 2) | WIN_W'(code.bits);
    rev_nxt = (rev_base >> 2) | (WIN_W'(code.bits ^ 2'b01) << (WIN_W - 2));

    cnt_nxt = (cnt_base < CNT_FULL) ? cnt_base + 1'b1 : cnt_base;
    if (!code.ok) begin
      run_nxt = '0;
    end else if (run_base < CNT_FULL) begin
      run_nxt = run_base + 1'b1;
    end else begin
      run_nxt = run_base;
    end

    status.full  = (cnt_nxt == CNT_FULL);
    status.clean = (run_nxt == CNT_FULL);

    min_win = (fwd_nxt < rev_nxt) ? fwd_nxt : rev_nxt;
    canon   = status.clean ? CANON_W'(min_win) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
      rev_r <= '0;
      cnt_r <= '0;
      run_r <= '0;
    end else if (step) begin
      fwd_r <= fwd_nxt;
      rev_r <= rev_nxt;
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

@@ rtl/canonical_kmer_indexer.sv @@
// Top level of the canonical k-mer indexer: handshakes, position, block and
// sampling counters, configuration registers and the result register.
// Depends on ckmer_pkg and ckmer_window.
//
// Usage: the input channel takes one ASCII base per item together with a
// start-of-sequence flag. From the KMER_LEN-th base of a sequence on,
// every base yields one result item: the window start position, the
// canonical (smaller of forward and reverse-complement) 2-bit-coded index, the
// cumulative block number, a window-valid flag and a sample flag. Earlier
// bases of a sequence yield no item.
// A result is registered at the edge that accepts its base. Throughput is
// one item per cycle, set by the single result register; a new base is taken
// in the same cycle that the waiting result is taken.
// When the receiver stalls with a result pending, in_ready drops until that
// result is taken, so nothing is lost or repeated.
// Reset (synchronous, active low) clears the windows and all counters and
// loads a block period of 500 and a sample stride of 10. The configuration
// port writes a register with no handshake; it should only be written while
// no item is in flight.
module canonical_kmer_indexer #(
  parameter int unsigned KMER_LEN = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_base_char,
  input  logic                             in_seq_start,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ckmer_pkg::CANON_W-1:0]    out_canonical_index,
  output logic [ckmer_pkg::POS_W-1:0]      out_window_start,
  output logic [ckmer_pkg::BLK_W-1:0]      out_block_number,
  output logic                             out_window_valid,
  output logic                             out_sample_hit,

  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ckmer_pkg::CFG_W-1:0]      cfg_wdata
);
  import ckmer_pkg::*;

  // Configuration registers.
  logic [BSIZE_W-1:0]  blk_period_r;
  logic [STRIDE_W-1:0] sample_stride_r;

  // Sequence counters.
  logic [POS_W-1:0]    pos_r, pos_nxt, pos_base;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [BSIZE_W-1:0]  bph_r, bph_nxt, bph_base;
  logic [STRIDE_W-1:0] sph_r, sph_nxt, sph_base;
  logic [BSIZE_W:0]    bph_inc;
  logic [STRIDE_W:0]   sph_inc;

  // Result register.
  logic                out_valid_r;
  logic [CANON_W-1:0]  canon_r;
  logic [POS_W-1:0]    wstart_r;
  logic [BLK_W-1:0]    blkno_r;
  logic                wvalid_r;
  logic                hit_r;

  logic                accept;
  logic                emit;
  logic                hit;
  base_code_t          code;
  win_status_t         status;
  logic [CANON_W-1:0]  canon;

  // The result register is free when empty or being drained this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign code     = decode_base(in_base_char);

  ckmer_window #(
    .KMER_LEN (KMER_LEN)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .seq_start (in_seq_start),
    .code      (code),
    .status    (status),
    .canon     (canon)
  );

  assign emit = status.full;

  // A new sequence restarts position and both phases; the block number
  // carries across sequences. Counters only move on window starts.
  always_comb begin
    pos_base = in_seq_start ? '0 : pos_r;
    bph_base = in_seq_start ? '0 : bph_r;
    sph_base = in_seq_start ? '0 : sph_r;

    bph_inc = {1'b0, bph_base} + 1'b1;
    sph_inc = {1'b0, sph_base} + 1'b1;
    hit     = (sph_base == '0);

    pos_nxt = pos_base;
    blk_nxt = blk_r;
    bph_nxt = bph_base;
    sph_nxt = sph_base;
    if (emit) begin
      if (bph_base == '0 && blk_r != BLK_MAX) begin
        blk_nxt = blk_r + 1'b1;
      end
      if (pos_base != POS_MAX) begin
        pos_nxt = pos_base + 1'b1;
      end
      // A zero period behaves as one, and a phase left beyond a newly
      // written period wraps to zero here.
      bph_nxt = (bph_inc >= {1'b0, blk_period_r}) ? '0 : bph_inc[BSIZE_W-1:0];
      sph_nxt = (sph_inc >= {1'b0, sample_stride_r}) ? '0 : sph_inc[STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_period_r    <= BLOCK_SIZE_RST;
      sample_stride_r <= SAMPLE_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:    blk_period_r    <= cfg_wdata[BSIZE_W-1:0];
        CFG_SAMPLE_STRIDE: sample_stride_r <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      blk_r <= '0;
      bph_r <= '0;
      sph_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      blk_r <= blk_nxt;
      bph_r <= bph_nxt;
      sph_r <= sph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      canon_r  <= canon;
      wstart_r <= pos_base;
      blkno_r  <= blk_nxt;
      wvalid_r <= status.clean;
      hit_r    <= hit;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_canonical_index = canon_r;
  assign out_window_start    = wstart_r;
  assign out_block_number    = blkno_r;
  assign out_window_valid    = wvalid_r;
  assign out_sample_hit      = hit_r;

  // An invalid window always reports a zero index.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_window_valid) |-> (out_canonical_index == '0))
    else $error("invalid window carries a nonzero index");

  // Within a sequence the start position never moves backward.
  a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_seq_start) |=> (pos_r >= $past(pos_r)))
    else $error("start position decreased within a sequence");

  // The cumulative block number never decreases.
  a_blk_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (blk_r >= $past(blk_r)))
    else $error("block number decreased");

  // A pending result that is not taken blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !accept)
    else $error("item accepted while result register is stalled");

endmodule

@@ sim/kmer_result_checker.sv @@
// Result checker for the canonical k-mer indexer: keeps its own forward and
// reverse-complement windows, predicts the result item of each accepted base
// that yields one, checks every result item as it is taken. Depends on ckmer_pkg.
module kmer_result_checker #(
  parameter int unsigned KMER_LEN = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_base_char,
  input  logic                           in_seq_start,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ckmer_pkg::CANON_W-1:0]  out_canonical_index,
  input  logic [ckmer_pkg::POS_W-1:0]    out_window_start,
  input  logic [ckmer_pkg::BLK_W-1:0]    out_block_number,
  input  logic                           out_window_valid,
  input  logic                           out_sample_hit,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ckmer_pkg::CFG_W-1:0]    cfg_wdata,
  output int                             mismatch_cnt,
  output int                             pending_kmers
);
  timeunit 1ns;
  timeprecision 1ps;
  import ckmer_pkg::*;

  localparam int unsigned WIN_BITS = 2 * KMER_LEN;
  localparam logic [63:0] WIN_MASK =
    (KMER_LEN >= 32) ? '1 : ((64'd1 << WIN_BITS) - 64'd1);

  typedef struct packed {
    logic [CANON_W-1:0] canon;
    logic [POS_W-1:0]   start;
    logic [BLK_W-1:0]   block;
    logic               valid;
    logic               hit;
  } kmer_result_t;

  kmer_result_t expected_kmers[$];

  logic [63:0]         fwd_win;
  logic [63:0]         rev_win;
  int unsigned         fill_cnt;
  int unsigned         clean_cnt;
  logic [POS_W-1:0]    start_pos;
  logic [BLK_W-1:0]    blk_cnt;
  logic [BSIZE_W-1:0]  blk_phase;
  logic [STRIDE_W-1:0] smp_phase;
  logic [BSIZE_W-1:0]  blk_size;
  logic [STRIDE_W-1:0] smp_stride;

  function automatic void clear_window();
    fwd_win   = '0;
    rev_win   = '0;
    fill_cnt  = 0;
    clean_cnt = 0;
    start_pos = '0;
    blk_phase = '0;
    smp_phase = '0;
  endfunction

  // Roll one base into both windows and report the result item it yields.
  task automatic roll_base(input logic [7:0] ch, input logic first,
                           output bit emitted, output kmer_result_t r);
    logic [1:0]  code;
    logic        ok;
    logic [63:0] canon;
    int unsigned nxt;
    emitted = 1'b0;
    r       = '0;
    ok      = 1'b1;
    code    = CODE_A;
    // Clearing bit 5 folds lower case onto upper case for letters only.
    case (ch & 8'hDF)
      CHAR_A_UP: code = CODE_A;
      CHAR_T_UP: code = CODE_T;
      CHAR_C_UP: code = CODE_C;
      CHAR_G_UP: code = CODE_G;
      default:   ok = 1'b0;
    endcase
    if (first) clear_window();
    fwd_win = ((fwd_win << 2) | 64'(code)) & WIN_MASK;
    rev_win = (rev_win >> 2) | (64'(code ^ 2'd1) << (2 * (KMER_LEN - 1)));
    if (fill_cnt < KMER_LEN) fill_cnt++;
    if (!ok) clean_cnt = 0;
    else if (clean_cnt < KMER_LEN) clean_cnt++;
    if (fill_cnt >= KMER_LEN) begin
      if (blk_phase == '0 && blk_cnt < BLK_MAX) blk_cnt++;
      canon   = (fwd_win < rev_win) ? fwd_win : rev_win;
      r.valid = (clean_cnt >= KMER_LEN);
      r.canon = r.valid ? canon[CANON_W-1:0] : '0;
      r.start = start_pos;
      r.block = blk_cnt;
      r.hit   = (smp_phase == '0);
      emitted = 1'b1;
      if (start_pos < POS_MAX) start_pos++;
      nxt       = blk_phase + 1;
      blk_phase = (nxt >= blk_size) ? '0 : BSIZE_W'(nxt);
      nxt       = smp_phase + 1;
      smp_phase = (nxt >= smp_stride) ? '0 : STRIDE_W'(nxt);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    kmer_result_t want;
    kmer_result_t got;
    bit           emitted;
    if (!rst_n) begin
      clear_window();
      blk_cnt      = '0;
      blk_size     = BLOCK_SIZE_RST;
      smp_stride   = SAMPLE_STRIDE_RST;
      mismatch_cnt = 0;
      expected_kmers.delete();
    end else begin
      // The result taken at this edge is always older than the base taken here.
      if (out_valid && out_ready) begin
        if (expected_kmers.size() == 0) begin
          $error("unexpected result item with window_start 0x%0h", out_window_start);
          mismatch_cnt++;
        end else begin
          want = expected_kmers.pop_front();
          got  = '{out_canonical_index, out_window_start, out_block_number,
                   out_window_valid, out_sample_hit};
          check_field("canonical_index", want.canon, got.canon);
          check_field("window_start", want.start, got.start);
          check_field("block_number", want.block, got.block);
          check_field("window_valid", want.valid, got.valid);
          check_field("sample_hit", want.hit, got.hit);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_SIZE:    blk_size = cfg_wdata[BSIZE_W-1:0];
          CFG_SAMPLE_STRIDE: smp_stride = cfg_wdata[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        roll_base(in_base_char, in_seq_start, emitted, want);
        if (emitted) expected_kmers.insert(expected_kmers.size(), want);
      end
    end
    pending_kmers = expected_kmers.size();
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the canonical k-mer indexer: drives bases and register
// writes, stalls the result side, and reports the verdict.
// Depends on ckmer_pkg, canonical_kmer_indexer and kmer_result_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ckmer_pkg::*;

  localparam int unsigned KMER_LEN    = 16;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned STALL_LIMIT = 1000;

  localparam logic [7:0] NUCLEOTIDES [8] = '{
    CHAR_A_UP, CHAR_T_UP, CHAR_C_UP, CHAR_G_UP,
    CHAR_A_LO, CHAR_T_LO, CHAR_C_LO, CHAR_G_LO
  };

  // The opening stream: seventeen clean bases that use every letter in both
  // cases, then a NUL, an 'N' and an all-ones byte that poison the next
  // windows, then a few clean bases again. No sequence flag is sent, so the
  // block must treat the stream as a sequence begun at reset.
  localparam logic [7:0] DIRECTED_BASES [24] = '{
    CHAR_A_UP, CHAR_C_UP, CHAR_G_UP, CHAR_T_UP, CHAR_A_LO, CHAR_C_LO,
    CHAR_G_LO, CHAR_T_LO, CHAR_G_UP, CHAR_G_UP, CHAR_C_LO, CHAR_T_UP,
    CHAR_A_LO, CHAR_A_UP, CHAR_T_LO, CHAR_C_UP, CHAR_G_LO, 8'h00,
    8'h4E,     8'hFF,     CHAR_G_UP, CHAR_A_UP, CHAR_T_UP, CHAR_C_LO
  };

  // Register settings per phase. They include the smallest and largest
  // legal values and a zero, which the block must treat as a period of one.
  localparam logic [BSIZE_W-1:0] BLOCK_SETTINGS [NUM_PHASES] = '{
    16'd3, 16'd1, 16'd65535, 16'd0, 16'd7, 16'd500, 16'd2, 16'd13
  };
  localparam logic [STRIDE_W-1:0] STRIDE_SETTINGS [NUM_PHASES] = '{
    8'd4, 8'd255, 8'd1, 8'd0, 8'd3, 8'd10, 8'd1, 8'd6
  };

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [7:0]          in_base_char = '0;
  logic                in_seq_start = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b1;
  logic [CANON_W-1:0]  out_canonical_index;
  logic [POS_W-1:0]    out_window_start;
  logic [BLK_W-1:0]    out_block_number;
  logic                out_window_valid;
  logic                out_sample_hit;
  logic                cfg_we       = 1'b0;
  logic                cfg_index    = CFG_BLOCK_SIZE;
  logic [CFG_W-1:0]    cfg_wdata    = '0;

  int                  mismatch_cnt;
  int                  pending_kmers;
  int unsigned         items_sent   = 0;
  int unsigned         stall_left   = 0;
  int unsigned         quiet_cycles = 0;
  bit                  no_idle      = 1'b0;

  canonical_kmer_indexer #(
    .KMER_LEN(KMER_LEN)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_base_char        (in_base_char),
    .in_seq_start        (in_seq_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_canonical_index (out_canonical_index),
    .out_window_start    (out_window_start),
    .out_block_number    (out_block_number),
    .out_window_valid    (out_window_valid),
    .out_sample_hit      (out_sample_hit),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  kmer_result_checker #(
    .KMER_LEN(KMER_LEN)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_base_char        (in_base_char),
    .in_seq_start        (in_seq_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_canonical_index (out_canonical_index),
    .out_window_start    (out_window_start),
    .out_block_number    (out_block_number),
    .out_window_valid    (out_window_valid),
    .out_sample_hit      (out_sample_hit),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .mismatch_cnt        (mismatch_cnt),
    .pending_kmers       (pending_kmers)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls in bursts of random length. A burst starts
  // rarely enough that long stretches run at full rate, and the final phase
  // never stalls at all.
  always @(negedge clk) begin
    if (!no_idle && stall_left == 0 && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // The watchdog ends the run if no item moves on either channel for too
  // long, which also catches a result that never arrives.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly clean letters in either case, with the odd random byte that is
  // usually not a nucleotide at all.
  function automatic logic [7:0] pick_base();
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    return NUCLEOTIDES[$urandom_range(0, 7)];
  endfunction

  // Present one base and hold it until the block takes it. Valid rises at a
  // falling edge and is only dropped when the sender decides to idle.
  task automatic send_base(input logic [7:0] ch, input logic first);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_base_char <= ch;
    in_seq_start <= first;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  // Stop sending and wait until every predicted result item has been taken.
  // A base that yields nothing still updates the state at its own edge, so
  // a few extra cycles cover it before a register may change.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_kmers != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned         phase_end;
    int unsigned         seq_len;
    bit                  carry_on;
    logic [BSIZE_W-1:0]  blk_set;
    logic [STRIDE_W-1:0] stride_set;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset register values.
    foreach (DIRECTED_BASES[i]) send_base(DIRECTED_BASES[i], 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      blk_set    = BLOCK_SETTINGS[ph];
      stride_set = STRIDE_SETTINGS[ph];
      if (ph == 4) begin
        blk_set    = BSIZE_W'($urandom_range(1, 65535));
        stride_set = STRIDE_W'($urandom_range(1, 255));
      end
      drain();
      program_reg(CFG_BLOCK_SIZE, blk_set);
      // The upper byte of the write data is noise that the stride ignores.
      program_reg(CFG_SAMPLE_STRIDE, {8'($urandom), stride_set});
      if (ph == NUM_PHASES - 1) no_idle = 1'b1;

      // In some phases the first sequence carries on from the last phase, so
      // the new periods take effect in the middle of a sequence.
      carry_on  = (ph % 3 == 1);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        // Most sequences are a little longer than one window; some are too
        // short to yield anything, and a few run long enough to wrap the
        // widest sampling stride.
        case ($urandom_range(0, 9))
          0:       seq_len = $urandom_range(1, KMER_LEN - 1);
          1:       seq_len = $urandom_range(200, 400);
          default: seq_len = $urandom_range(KMER_LEN, 4 * KMER_LEN);
        endcase
        for (int i = 0; i < seq_len; i++) begin
          send_base(pick_base(), (i == 0) && !carry_on);
        end
        carry_on = 1'b0;
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
